// ----- rtl/core/hfr_pkg.sv -----
// hfr_pkg: shared types, constants and the crc-16/x-25 byte step for the hdlc frame receiver
// no dependencies; imported by every module under rtl/core
package hfr_pkg;

  localparam int FRAME_BYTES_DEF = 512;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_FRAME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FORMAT    = 2'd1;

  localparam logic [9:0] MIN_FRAME_RST = 10'd18;
  localparam logic [3:0] FORMAT_RST    = 4'd10;

  localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
  localparam logic [7:0]  ESC_BYTE   = 8'h7D;
  localparam logic [7:0]  ESC_XOR    = 8'h20;
  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_XOROUT = 16'hFFFF;
  localparam logic [3:0]  HDR_BASE   = 4'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_SHORT      = 3'd2;
  localparam logic [2:0] ST_BAD_FORMAT = 3'd3;
  localparam logic [2:0] ST_BAD_DEST   = 3'd4;
  localparam logic [2:0] ST_BAD_SRC    = 3'd5;
  localparam logic [2:0] ST_HDR_FCS    = 3'd6;
  localparam logic [2:0] ST_FRAME_FCS  = 3'd7;

  typedef struct packed {
    logic [9:0] min_frame_bytes;
    logic [3:0] format_nibble;
  } cfg_t;

  typedef struct packed {
    logic [15:0] crc;
    logic [15:0] head_bytes;
    logic [23:0] dest_addr;
    logic [1:0]  dest_len;
    logic [23:0] src_addr;
    logic [1:0]  src_len;
    logic [15:0] hdr_crc_snap;
    logic [15:0] hdr_fcs;
    logic [15:0] last_two;
    logic [31:0] delayed_crc;
    logic [2:0]  dest_seen;
    logic [2:0]  src_seen;
    logic [3:0]  hdr_pos;
    logic [1:0]  hdr_got;
    logic        dest_done;
    logic        dest_bad;
    logic        src_done;
    logic        src_bad;
  } frame_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] dest_address;
    logic [1:0]  dest_length;
    logic [23:0] src_address;
    logic [1:0]  src_length;
    logic [11:0] length_field;
    logic [9:0]  stored_bytes;
  } result_t;

  function automatic frame_t frame_clear();
    frame_t f;
    f              = '0;
    f.crc          = CRC_INIT;
    f.delayed_crc  = {CRC_INIT, CRC_INIT};
    f.hdr_pos      = HDR_BASE;
    return f;
  endfunction

  function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/hfr_cfg_regs.sv -----
// hfr_cfg_regs: configuration registers (minimum frame length, format nibble)
// depends on hfr_pkg
module hfr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output hfr_pkg::cfg_t                 cfg
);
  import hfr_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_frame_bytes <= MIN_FRAME_RST;
      cfg_r.format_nibble   <= FORMAT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_IDX_MIN_FRAME) begin
        cfg_r.min_frame_bytes <= cfg_wdata[9:0];
      end else if (cfg_index == CFG_IDX_FORMAT) begin
        cfg_r.format_nibble <= cfg_wdata[3:0];
      end
    end
  end

endmodule

// ----- rtl/core/hfr_status_eval.sv -----
// hfr_status_eval: closing-flag checks, builds the status transaction from frame state
// depends on hfr_pkg
module hfr_status_eval #(
  parameter int FRAME_BYTES = hfr_pkg::FRAME_BYTES_DEF
) (
  input  hfr_pkg::frame_t                      fr,
  input  logic [$clog2(FRAME_BYTES+1)-1:0]     cnt,
  input  hfr_pkg::cfg_t                        cfg,
  output hfr_pkg::result_t                     res
);
  import hfr_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int CMP_W = (CNT_W > 10) ? CNT_W : 10;

  logic        show_dst;
  logic        show_src;
  logic [15:0] frame_fcs;
  logic [15:0] frame_calc;
  logic        hdr_ok;

  always_comb begin
    frame_fcs  = {fr.last_two[7:0], fr.last_two[15:8]};
    frame_calc = fr.delayed_crc[31:16] ^ CRC_XOROUT;
    hdr_ok     = (fr.hdr_got == 2'd2) && ((fr.hdr_crc_snap ^ CRC_XOROUT) == fr.hdr_fcs);
    show_dst   = 1'b0;
    show_src   = 1'b0;
    priority if (cnt == '0) begin
      res.status = ST_EMPTY;
    end else if (CMP_W'(cnt) <= CMP_W'(cfg.min_frame_bytes)) begin
      res.status = ST_SHORT;
    end else if (fr.head_bytes[7:4] != cfg.format_nibble) begin
      res.status = ST_BAD_FORMAT;
    end else if (fr.dest_bad) begin
      res.status = ST_BAD_DEST;
    end else if (fr.src_bad) begin
      res.status = ST_BAD_SRC;
      show_dst   = 1'b1;
    end else begin
      show_dst = 1'b1;
      show_src = 1'b1;
      priority if (!hdr_ok) begin
        res.status = ST_HDR_FCS;
      end else if ((cnt < CNT_W'(2)) || (frame_fcs != frame_calc)) begin
        res.status = ST_FRAME_FCS;
      end else begin
        res.status = ST_OK;
      end
    end
    res.dest_address = (show_dst && fr.dest_done) ? fr.dest_addr : 24'h0;
    res.dest_length  = (show_dst && fr.dest_done) ? fr.dest_len : 2'd0;
    res.src_address  = (show_src && fr.src_done) ? fr.src_addr : 24'h0;
    res.src_length   = (show_src && fr.src_done) ? fr.src_len : 2'd0;
    res.length_field = {fr.head_bytes[3:0], fr.head_bytes[15:8]};
    res.stored_bytes = 10'(cnt);
  end

endmodule

// ----- rtl/core/hfr_tracker.sv -----
// hfr_tracker: receive mode, unescaping, running crc, header and address tracking
// depends on hfr_pkg and hfr_status_eval
module hfr_tracker #(
  parameter int FRAME_BYTES = hfr_pkg::FRAME_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  hfr_pkg::cfg_t    cfg,
  output logic             res_valid,
  output hfr_pkg::result_t res
);
  import hfr_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);

  localparam logic [1:0] MODE_WAIT = 2'd0;
  localparam logic [1:0] MODE_DATA = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;

  logic [1:0]       mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  frame_t           fr_r, fr_nxt;

  frame_t           fs;
  logic [CNT_W-1:0] k;
  logic [7:0]       sb;
  logic             is_close;

  hfr_status_eval #(.FRAME_BYTES(FRAME_BYTES)) u_eval (
    .fr  (fr_r),
    .cnt (cnt_r),
    .cfg (cfg),
    .res (res)
  );

  assign is_close  = (mode_r == MODE_DATA) && (rx_byte == FLAG_BYTE);
  assign res_valid = step && is_close;

  // byte store path
  always_comb begin
    sb = (mode_r == MODE_ESC) ? (rx_byte ^ ESC_XOR) : rx_byte;
    if (cnt_r >= CNT_W'(FRAME_BYTES)) begin
      fs = frame_clear();
      k  = '0;
    end else begin
      fs = fr_r;
      k  = cnt_r;
    end

    if (k == CNT_W'(0)) begin
      fs.head_bytes[7:0] = fs.head_bytes[7:0] | sb;
    end else if (k == CNT_W'(1)) begin
      fs.head_bytes[15:8] = fs.head_bytes[15:8] | sb;
    end

    if ((k >= CNT_W'(2)) && !fs.dest_done) begin
      if (fs.dest_seen < 3'd4) begin
        fs.dest_seen = fs.dest_seen + 3'd1;
      end
      unique case (fs.dest_seen)
        3'd1:    fs.dest_addr[7:0]   = fs.dest_addr[7:0] | sb;
        3'd2:    fs.dest_addr[15:8]  = fs.dest_addr[15:8] | sb;
        3'd3:    fs.dest_addr[23:16] = fs.dest_addr[23:16] | sb;
        default: fs.dest_addr        = fs.dest_addr;
      endcase
      if (sb[0]) begin
        fs.dest_done = 1'b1;
        if (fs.dest_seen > 3'd3) begin
          fs.dest_bad = 1'b1;
        end else begin
          fs.dest_len = fs.dest_seen[1:0];
          fs.hdr_pos  = HDR_BASE + {1'b0, fs.dest_seen};
          fs.hdr_got  = 2'd0;
        end
      end
    end else if ((k >= CNT_W'(2)) && fs.dest_done && !fs.dest_bad && !fs.src_done) begin
      if (fs.src_seen < 3'd4) begin
        fs.src_seen = fs.src_seen + 3'd1;
      end
      unique case (fs.src_seen)
        3'd1:    fs.src_addr[7:0]   = fs.src_addr[7:0] | sb;
        3'd2:    fs.src_addr[15:8]  = fs.src_addr[15:8] | sb;
        3'd3:    fs.src_addr[23:16] = fs.src_addr[23:16] | sb;
        default: fs.src_addr        = fs.src_addr;
      endcase
      if (sb[0]) begin
        fs.src_done = 1'b1;
        if (fs.src_seen > 3'd3) begin
          fs.src_bad = 1'b1;
        end else begin
          fs.src_len = fs.src_seen[1:0];
          fs.hdr_pos = HDR_BASE + {2'b00, fs.dest_len} + {1'b0, fs.src_seen};
          fs.hdr_got = 2'd0;
        end
      end
    end

    if (k == CNT_W'(fs.hdr_pos)) begin
      fs.hdr_crc_snap = fs.crc;
      fs.hdr_fcs      = {8'h00, sb};
      fs.hdr_got      = 2'd1;
    end else if ((k == CNT_W'(fs.hdr_pos) + CNT_W'(1)) && (fs.hdr_got == 2'd1)) begin
      fs.hdr_fcs[15:8] = sb;
      fs.hdr_got       = 2'd2;
    end

    fs.delayed_crc = {fs.delayed_crc[15:0], fs.crc};
    fs.crc         = crc_step(fs.crc, sb);
    fs.last_two    = {fs.last_two[7:0], sb};
  end

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    fr_nxt   = fr_r;
    if (step) begin
      unique case (mode_r)
        MODE_DATA: begin
          if (is_close) begin
            mode_nxt = ((res.status >= ST_HDR_FCS) || (res.status == ST_OK)) ? MODE_WAIT
                                                                             : MODE_DATA;
            fr_nxt   = frame_clear();
            cnt_nxt  = '0;
          end else if (rx_byte == ESC_BYTE) begin
            mode_nxt = MODE_ESC;
          end else begin
            fr_nxt  = fs;
            cnt_nxt = k + CNT_W'(1);
          end
        end
        MODE_ESC: begin
          fr_nxt   = fs;
          cnt_nxt  = k + CNT_W'(1);
          mode_nxt = MODE_DATA;
        end
        default: begin
          mode_nxt = MODE_WAIT;
          if (rx_byte == FLAG_BYTE) begin
            mode_nxt = MODE_DATA;
            fr_nxt   = frame_clear();
            cnt_nxt  = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_WAIT;
      cnt_r  <= '0;
      fr_r   <= frame_clear();
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      fr_r   <= fr_nxt;
    end
  end

endmodule

// ----- rtl/core/hdlc_frame_receiver.sv -----
// hdlc_frame_receiver: top level, input register, frame tracker and result register
// depends on hfr_pkg, hfr_cfg_regs, hfr_tracker (which uses hfr_status_eval)
//
//   channel   handshake               payload
//   in_       in_valid / in_stall     in_rx_byte
//   out_      out_valid / out_stall   status, addresses, lengths, length field, stored bytes
//   cfg_      cfg_valid / cfg_ready   cfg_index, cfg_wdata
//
// one received byte per cycle while in_stall is low; a closing flag's result goes from the input
// register into the result register, which shows it as valid on out_
// rst_n is synchronous: mode returns to waiting for a flag, the valid, config and tracker registers
// to their defaults (byte_r and res_r are not reset); out_stall holds the result register; the byte in
// the input register moves on every cycle except a flag while the result register is held, and in_stall rises meanwhile
module hdlc_frame_receiver #(
  parameter int FRAME_BYTES = hfr_pkg::FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_status,
  output logic [23:0]                    out_dest_address,
  output logic [1:0]                     out_dest_length,
  output logic [23:0]                    out_src_address,
  output logic [1:0]                     out_src_length,
  output logic [11:0]                    out_length_field,
  output logic [9:0]                     out_stored_bytes,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hfr_pkg::*;

  cfg_t       cfg;
  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       out_vld_r;
  result_t    res_r;
  result_t    res;
  logic       res_valid;
  logic       fire;
  logic       out_free;

  hfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hfr_tracker #(.FRAME_BYTES(FRAME_BYTES)) u_trk (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (fire),
    .rx_byte   (byte_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free = !out_vld_r || !out_stall;
  // only a flag byte waits for room in the result register; only a closing flag uses it
  assign fire     = in_vld_r && (out_free || (byte_r != FLAG_BYTE));
  assign in_stall = in_vld_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_valid) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = res_r.status;
  assign out_dest_address = res_r.dest_address;
  assign out_dest_length  = res_r.dest_length;
  assign out_src_address  = res_r.src_address;
  assign out_src_length   = res_r.src_length;
  assign out_length_field = res_r.length_field;
  assign out_stored_bytes = res_r.stored_bytes;

endmodule
